/* src/ppe_pkg.sv */
// ----------------------------------------------------------------------------
// Particle pool engine package
// Shared types and constants for the particle pool engine.
// ----------------------------------------------------------------------------
package ppe_pkg;

    typedef enum logic [1:0] {
        CMD_EMIT   = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_RENDER = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_COLOUR_BEGIN = 3'd0,
        REG_COLOUR_END   = 3'd1,
        REG_SIZE_BEGIN   = 3'd2,
        REG_SIZE_END     = 3'd3,
        REG_SPREAD_X     = 3'd4,
        REG_SPREAD_Y     = 3'd5,
        REG_SPREAD_Z     = 3'd6,
        REG_SPIN_SPREAD  = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMIT,
        ST_TICK_RD,
        ST_TICK_WAIT,
        ST_TICK_CALC,
        ST_TICK_WR,
        ST_REN_RD,
        ST_REN_WAIT,
        ST_REN_DIV,
        ST_REN_LERP,
        ST_REN_OUT,
        ST_REN_EMPTY
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] start_angle;
        logic signed [31:0] base_vx;
        logic signed [31:0] base_vy;
        logic signed [31:0] base_vz;
        logic signed [31:0] base_spin;
        logic [15:0] duration;
        logic [15:0] rand_linear;
        logic [15:0] rand_angular;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_angle;
        logic [15:0] quad_size;
        logic [31:0] colour;
        logic        is_last;
        logic        is_empty;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg_item;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* src/ppe_if.sv */
// ----------------------------------------------------------------------------
// Particle pool engine channels
// Valid and ready channels for input items, result items and configuration.
// ----------------------------------------------------------------------------
interface ppe_in_if;
    logic               valid;
    logic               ready;
    ppe_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ppe_out_if;
    logic               valid;
    logic               ready;
    ppe_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ppe_cfg_if;
    logic               valid;
    logic               ready;
    ppe_pkg::t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/ppe_ram.sv */
// ----------------------------------------------------------------------------
// Particle pool engine RAM
// Single port write, single port read memory with registered read data.
// ----------------------------------------------------------------------------
module ppe_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/ppe_div.sv */
// ----------------------------------------------------------------------------
// Particle pool engine ratio divider
// Restoring divider giving min(floor(num * 65536 / den), 65536), one bit a cycle.
// ----------------------------------------------------------------------------
module ppe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [16:0] o_quot
);
    // num < 2^16 and den >= 1, so the quotient fits 32 bits; 17 low bits plus a cap.
    logic [32:0] r_rem;
    logic [31:0] r_q;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_rem;
    logic [32:0] w_try;

    assign w_try = {r_rem[31:0], r_q[31]};

    always_comb begin
        n_rem = w_try;
        if (w_try >= {17'd0, r_den}) begin
            n_rem = w_try - {17'd0, r_den};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= {i_num, 16'd0};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[30:0], (w_try >= {17'd0, r_den})};
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_q[31:16] != 16'd0) ? 17'h10000
                  : (r_q[16] ? 17'h10000 : {1'b0, r_q[15:0]});
endmodule

/* src/particle_pool_engine.sv */
// ----------------------------------------------------------------------------
// Particle pool engine
// Ring pool of particles with emit, Euler tick and interpolated render.
// ----------------------------------------------------------------------------
// Usage: items arrive on the input channel and carry a command. Emit writes
// the next ring slot and gives no result. Tick walks every slot and advances
// active particles; it gives no result. Render walks every slot and gives one
// result item per active particle in slot order, the last flagged by is_last;
// an empty pool gives a single item with is_empty and is_last set.
// Configuration writes use their own channel and are taken at any time; they
// should only be issued while the block is idle.
// Emit keeps the block busy after it is accepted while the shared multiplier
// forms the four motion components. Tick time for an active slot with a
// positive life is set by one shared multiplier that handles the four motion
// components in turn and the read, modify, write of the pool memories. Render
// time for such a slot with a nonzero lifetime is set by the 32 step ratio
// divider and the shared interpolation multiplier, for other active slots by
// the multiplier alone, plus any output stall. The block accepts no item while
// one is in progress. When the receiver stalls, the walk holds at the pending
// result. Reset clears the active flags, the write slot and the control
// registers and sets configuration defaults; pool memories need no clearing.
// ----------------------------------------------------------------------------
module particle_pool_engine #(
    parameter int POOL_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ppe_in_if.sink           in_ch,
    ppe_out_if.source        out_ch,
    ppe_cfg_if.sink          cfg_ch
);
    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int NM = 10;

    ppe_pkg::t_state r_state, n_state;

    logic [31:0] r_col_b, r_col_e;
    logic [15:0] r_size_b, r_size_e;
    logic signed [31:0] r_spr [4];

    logic [POOL_DEPTH-1:0] r_alive;
    logic [AW-1:0] r_wslot;
    logic [AW-1:0] r_idx;
    logic          r_any;
    ppe_pkg::t_in_item r_item;

    // Memory index 0..3 pos/angle, 4..7 vel/spin, 8 life left, 9 lifetime.
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata [NM];
    logic [31:0]   w_rdata [NM];

    logic signed [31:0] r_res [4];
    logic signed [31:0] r_mul_a;
    logic signed [32:0] r_mul_b;
    logic signed [64:0] w_prod;
    logic [2:0]  r_mstep;

    logic        w_div_start, w_div_done;
    logic [16:0] w_quot;
    logic [16:0] r_t;
    logic [15:0] r_size;
    logic [31:0] r_col;
    ppe_pkg::t_out_item r_out;
    logic        r_out_valid;

    logic signed [16:0] w_life;
    logic        w_last_slot;

    genvar g;
    generate
        for (g = 0; g < NM; g++) begin : g_mem
            ppe_ram #(.Width(32), .Depth(POOL_DEPTH)) u_mem (
                .i_clk  (i_clk),
                .i_we   (w_we),
                .i_waddr(w_waddr),
                .i_wdata(w_wdata[g]),
                .i_raddr(r_idx),
                .o_rdata(w_rdata[g])
            );
        end
    endgenerate

    ppe_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_rdata[8][15:0]),
        .i_den  (w_rdata[9][15:0]),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign w_life      = w_rdata[8][16:0];
    assign w_last_slot = (r_idx == AW'(POOL_DEPTH - 1));
    assign w_prod      = r_mul_a * r_mul_b;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_b  <= 32'hFFFF_FFFF;
            r_col_e  <= '0;
            r_size_b <= 16'd256;
            r_size_e <= '0;
            for (int k = 0; k < 4; k++) r_spr[k] <= '0;
        end else if (cfg_ch.valid) begin
            case (ppe_pkg::t_reg'(cfg_ch.data.index))
                ppe_pkg::REG_COLOUR_BEGIN: r_col_b  <= cfg_ch.data.data;
                ppe_pkg::REG_COLOUR_END:   r_col_e  <= cfg_ch.data.data;
                ppe_pkg::REG_SIZE_BEGIN:   r_size_b <= cfg_ch.data.data[15:0];
                ppe_pkg::REG_SIZE_END:     r_size_e <= cfg_ch.data.data[15:0];
                ppe_pkg::REG_SPREAD_X:     r_spr[0] <= cfg_ch.data.data;
                ppe_pkg::REG_SPREAD_Y:     r_spr[1] <= cfg_ch.data.data;
                ppe_pkg::REG_SPREAD_Z:     r_spr[2] <= cfg_ch.data.data;
                ppe_pkg::REG_SPIN_SPREAD:  r_spr[3] <= cfg_ch.data.data;
                default: ;
            endcase
        end
    end

    assign in_ch.ready  = (r_state == ppe_pkg::ST_IDLE);
    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ppe_pkg::ST_IDLE: begin
                if (in_ch.valid) begin
                    case (ppe_pkg::t_cmd'(in_ch.data.command))
                        ppe_pkg::CMD_EMIT:   n_state = ppe_pkg::ST_EMIT;
                        ppe_pkg::CMD_TICK:   n_state = ppe_pkg::ST_TICK_RD;
                        ppe_pkg::CMD_RENDER: n_state = ppe_pkg::ST_REN_RD;
                        default:             n_state = ppe_pkg::ST_IDLE;
                    endcase
                end
            end
            ppe_pkg::ST_EMIT: begin
                if (r_mstep == 3'd5) n_state = ppe_pkg::ST_IDLE;
            end
            ppe_pkg::ST_TICK_RD: begin
                if (r_alive[r_idx]) n_state = ppe_pkg::ST_TICK_WAIT;
                else if (w_last_slot) n_state = ppe_pkg::ST_IDLE;
            end
            ppe_pkg::ST_TICK_WAIT: begin
                n_state = ppe_pkg::ST_TICK_CALC;
            end
            ppe_pkg::ST_TICK_CALC: begin
                if ($signed(w_life) <= 17'sd0) begin
                    n_state = w_last_slot ? ppe_pkg::ST_IDLE : ppe_pkg::ST_TICK_RD;
                end else if (r_mstep == 3'd5) begin
                    n_state = ppe_pkg::ST_TICK_WR;
                end
            end
            ppe_pkg::ST_TICK_WR: begin
                n_state = w_last_slot ? ppe_pkg::ST_IDLE : ppe_pkg::ST_TICK_RD;
            end
            ppe_pkg::ST_REN_RD: begin
                if (r_alive[r_idx]) n_state = ppe_pkg::ST_REN_WAIT;
                else if (w_last_slot) n_state = r_any ? ppe_pkg::ST_IDLE
                                                      : ppe_pkg::ST_REN_EMPTY;
            end
            ppe_pkg::ST_REN_WAIT: begin
                n_state = w_div_start ? ppe_pkg::ST_REN_DIV : ppe_pkg::ST_REN_LERP;
            end
            ppe_pkg::ST_REN_DIV: begin
                if (w_div_done) n_state = ppe_pkg::ST_REN_LERP;
            end
            ppe_pkg::ST_REN_LERP: begin
                if (r_mstep == 3'd6) n_state = ppe_pkg::ST_REN_OUT;
            end
            ppe_pkg::ST_REN_OUT: begin
                if (!r_out_valid || out_ch.ready) begin
                    n_state = w_last_slot ? ppe_pkg::ST_IDLE : ppe_pkg::ST_REN_RD;
                end
            end
            ppe_pkg::ST_REN_EMPTY: begin
                if (!r_out_valid || out_ch.ready) n_state = ppe_pkg::ST_IDLE;
            end
            default: n_state = ppe_pkg::ST_IDLE;
        endcase
    end

    // The divider runs only for a positive life with a nonzero lifetime.
    assign w_div_start = (r_state == ppe_pkg::ST_REN_WAIT) && (w_rdata[9][15:0] != 16'd0)
                       && ($signed(w_life) > 17'sd0);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        for (int k = 0; k < NM; k++) w_wdata[k] = w_rdata[k];
        case (r_state)
            ppe_pkg::ST_EMIT: begin
                w_we    = (r_mstep == 3'd5);
                w_waddr = r_wslot;
                w_wdata[0] = r_item.start_x;
                w_wdata[1] = r_item.start_y;
                w_wdata[2] = r_item.start_z;
                w_wdata[3] = r_item.start_angle;
                for (int k = 0; k < 4; k++) w_wdata[4+k] = r_res[k];
                w_wdata[8] = {16'd0, r_item.duration};
                w_wdata[9] = {16'd0, r_item.duration};
            end
            ppe_pkg::ST_TICK_WR: begin
                w_we = 1'b1;
                for (int k = 0; k < 4; k++) w_wdata[k] = r_res[k];
                w_wdata[8] = {15'd0, w_life - $signed({1'b0, r_item.duration})};
            end
            default: ;
        endcase
    end

    // Input capture, shared multiplier operand selection and result updates, one product per step.
    always_ff @(posedge i_clk) begin
        logic [7:0] ce, cb;
        logic signed [31:0] base;
        logic signed [63:0] sh;
        if (r_state == ppe_pkg::ST_IDLE && in_ch.valid) begin
            r_item  <= in_ch.data;
            r_mstep <= '0;
        end else if (r_state == ppe_pkg::ST_EMIT) begin
            r_mstep <= r_mstep + 3'd1;
            if (r_mstep < 3'd4) begin
                r_mul_a <= r_spr[r_mstep[1:0]];
                r_mul_b <= (r_mstep == 3'd3)
                         ? 33'($signed({1'b0, r_item.rand_angular}) - 17'sd32768)
                         : 33'($signed({1'b0, r_item.rand_linear}) - 17'sd32768);
            end
            if (r_mstep >= 3'd1 && r_mstep <= 3'd4) begin
                case (r_mstep)
                    3'd1:    base = r_item.base_vx;
                    3'd2:    base = r_item.base_vy;
                    3'd3:    base = r_item.base_vz;
                    default: base = r_item.base_spin;
                endcase
                sh = 64'(w_prod >>> 16);
                r_res[r_mstep[1:0] - 2'd1] <= ppe_pkg::sat32(64'(base) + sh);
            end
        end else if (r_state == ppe_pkg::ST_TICK_CALC) begin
            r_mstep <= r_mstep + 3'd1;
            if (r_mstep < 3'd4) begin
                r_mul_a <= w_rdata[4 + r_mstep[1:0]];
                r_mul_b <= 33'($signed({1'b0, r_item.duration}));
            end
            if (r_mstep >= 3'd1 && r_mstep <= 3'd4) begin
                sh = 64'(w_prod >>> 8);
                r_res[r_mstep[1:0] - 2'd1] <=
                    ppe_pkg::sat32(64'($signed(w_rdata[r_mstep[1:0] - 2'd1])) + sh);
            end
        end else if (r_state == ppe_pkg::ST_REN_DIV && w_div_done) begin
            r_t     <= w_quot;
            r_mstep <= '0;
        end else if (r_state == ppe_pkg::ST_REN_WAIT && !w_div_start) begin
            r_t <= '0;
        end else if (r_state == ppe_pkg::ST_REN_LERP) begin
            r_mstep <= r_mstep + 3'd1;
            if (r_mstep < 3'd5) begin
                r_mul_b <= 33'($signed({16'd0, r_t}));
                case (r_mstep)
                    3'd0:    r_mul_a <= 32'($signed({1'b0, r_size_b}) - $signed({1'b0, r_size_e}));
                    default: begin
                        cb = r_col_b[(r_mstep - 3'd1) * 8 +: 8];
                        ce = r_col_e[(r_mstep - 3'd1) * 8 +: 8];
                        r_mul_a <= 32'($signed({1'b0, cb}) - $signed({1'b0, ce}));
                    end
                endcase
            end
            if (r_mstep >= 3'd1 && r_mstep <= 3'd5) begin
                sh = 64'(w_prod >>> 16);
                if (r_mstep == 3'd1) begin
                    r_size <= r_size_e + sh[15:0];
                end else begin
                    ce = r_col_e[(r_mstep - 3'd2) * 8 +: 8];
                    r_col[(r_mstep - 3'd2) * 8 +: 8] <= ce + sh[7:0];
                end
            end
        end else if (r_state == ppe_pkg::ST_TICK_RD || r_state == ppe_pkg::ST_REN_RD) begin
            r_mstep <= '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppe_pkg::ST_IDLE;
            r_alive     <= '0;
            r_wslot     <= '0;
            r_idx       <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && out_ch.ready) r_out_valid <= 1'b0;
            case (r_state)
                ppe_pkg::ST_IDLE: begin
                    r_idx <= '0;
                    r_any <= 1'b0;
                end
                ppe_pkg::ST_EMIT: begin
                    if (r_mstep == 3'd5) begin
                        r_alive[r_wslot] <= 1'b1;
                        r_wslot <= (r_wslot == AW'(POOL_DEPTH - 1)) ? '0 : r_wslot + 1'b1;
                    end
                end
                ppe_pkg::ST_TICK_RD, ppe_pkg::ST_REN_RD: begin
                    if (!r_alive[r_idx] && !w_last_slot) r_idx <= r_idx + 1'b1;
                end
                ppe_pkg::ST_TICK_CALC: begin
                    if ($signed(w_life) <= 17'sd0) begin
                        r_alive[r_idx] <= 1'b0;
                        if (!w_last_slot) r_idx <= r_idx + 1'b1;
                    end
                end
                ppe_pkg::ST_TICK_WR: begin
                    if (!w_last_slot) r_idx <= r_idx + 1'b1;
                end
                ppe_pkg::ST_REN_OUT: begin
                    if (!r_out_valid || out_ch.ready) begin
                        r_out_valid <= 1'b1;
                        r_any       <= 1'b1;
                        if (!w_last_slot) r_idx <= r_idx + 1'b1;
                    end
                end
                ppe_pkg::ST_REN_EMPTY: begin
                    if (!r_out_valid || out_ch.ready) r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Result payload; is_last is set when no later slot is active.
    always_ff @(posedge i_clk) begin
        if (r_state == ppe_pkg::ST_REN_OUT && (!r_out_valid || out_ch.ready)) begin
            r_out.out_x     <= w_rdata[0];
            r_out.out_y     <= w_rdata[1];
            r_out.out_z     <= w_rdata[2];
            r_out.out_angle <= w_rdata[3];
            r_out.quad_size <= r_size;
            r_out.colour    <= r_col;
            r_out.is_last   <= ((r_alive >> r_idx) >> 1) == '0;
            r_out.is_empty  <= 1'b0;
        end else if (r_state == ppe_pkg::ST_REN_EMPTY && (!r_out_valid || out_ch.ready)) begin
            r_out          <= '0;
            r_out.is_last  <= 1'b1;
            r_out.is_empty <= 1'b1;
        end
    end
endmodule
